FILE: rtl/ipv6t_pkg.sv
// Package for the IPv6 text-to-binary parser.
// Holds shared widths, character codes, the queue word type and the hex decoder.
// No dependencies.
package ipv6t_pkg;

    localparam int MAX_CHARS  = 39;
    localparam int CC_W       = 6;
    localparam int CHAR_W     = 8;
    localparam int GROUP_W    = 16;
    localparam int NUM_GROUPS = 8;
    localparam int GIDX_W     = 3;
    localparam int GCNT_W     = 4;
    localparam int DC_W       = 3;
    localparam int ADDR_W     = 64;
    localparam int Q_DEPTH    = 2;
    localparam int Q_PTR_W    = 1;
    localparam int Q_CNT_W    = 2;

    localparam logic [CHAR_W-1:0] CHAR_COLON = 8'h3A;

    typedef struct packed {
        logic       is_hex;
        logic [3:0] value;
    } t_hex;

    // one queue word: an optional group write and an optional end-of-string mark
    typedef struct packed {
        logic               has_group;
        logic               to_tail;
        logic [GIDX_W-1:0]  idx;
        logic [GROUP_W-1:0] group;
        logic               finish;
        logic               ok;
        logic [GCNT_W-1:0]  nfront;
        logic [GCNT_W-1:0]  nback;
    } t_qentry;

    function automatic t_hex hex_decode(input logic [CHAR_W-1:0] c);
        t_hex r;
        r.is_hex = 1'b1;
        r.value  = '0;
        case (c) inside
            [8'h30:8'h39]: r.value = 4'(c - 8'h30);
            [8'h61:8'h66]: r.value = 4'(c - 8'h57);
            [8'h41:8'h46]: r.value = 4'(c - 8'h37);
            default:       r.is_hex = 1'b0;
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/ipv6t_front.sv
// Front end of the IPv6 parser: per-character syntax checks and group counting.
// Emits group writes and end-of-string words to the queue. Uses ipv6t_pkg.
module ipv6t_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_accept,
    input  logic [ipv6t_pkg::CHAR_W-1:0]     i_text_char,
    input  logic                             i_last_char,
    output logic                             o_push,
    output ipv6t_pkg::t_qentry               o_entry
);
    import ipv6t_pkg::*;

    logic [GROUP_W-1:0] r_accum, n_accum;
    logic [DC_W-1:0]    r_dc, n_dc;
    logic [GCNT_W-1:0]  r_front, n_front;
    logic [GCNT_W-1:0]  r_back, n_back;
    logic               r_gap, n_gap;
    logic               r_prev_colon, n_prev_colon;
    logic               r_at_start, n_at_start;
    logic [CC_W-1:0]    r_cc, n_cc;
    logic               r_failed, n_failed;

    t_hex               hex;
    logic [GCNT_W-1:0]  grp_n;
    logic [GCNT_W-1:0]  fin_n;
    logic [GCNT_W-1:0]  f2, b2;
    logic               fail;
    logic               ok;
    logic               colon_push;
    t_qentry            entry;

    always_comb begin
        n_accum      = r_accum;
        n_dc         = r_dc;
        n_front      = r_front;
        n_back       = r_back;
        n_gap        = r_gap;
        n_prev_colon = r_prev_colon;
        n_at_start   = r_at_start;
        n_cc         = r_cc;
        fail         = r_failed;
        colon_push   = 1'b0;
        entry        = '0;
        hex          = hex_decode(i_text_char);
        grp_n        = r_front + r_back;
        fin_n        = '0;
        f2           = '0;
        b2           = '0;
        ok           = 1'b0;

        if (!r_failed) begin
            if (r_cc >= CC_W'(MAX_CHARS)) begin
                fail = 1'b1;
            end
            if (r_cc != '1) begin
                n_cc = r_cc + 1'b1;
            end
        end

        if (!fail) begin
            if (hex.is_hex) begin
                if (r_dc[DC_W-1] || (r_at_start && r_prev_colon)) begin
                    fail = 1'b1;
                end else begin
                    n_accum      = {r_accum[GROUP_W-5:0], hex.value};
                    n_dc         = r_dc + 1'b1;
                    n_prev_colon = 1'b0;
                    n_at_start   = 1'b0;
                end
            end else if (i_text_char == CHAR_COLON) begin
                if (r_dc != '0) begin
                    if (grp_n[GCNT_W-1]) begin
                        fail = 1'b1;
                    end else begin
                        colon_push      = 1'b1;
                        entry.has_group = 1'b1;
                        entry.to_tail   = r_gap;
                        entry.idx       = grp_n[GIDX_W-1:0];
                        entry.group     = r_accum;
                        if (r_gap) begin
                            n_back = r_back + 1'b1;
                        end else begin
                            n_front = r_front + 1'b1;
                        end
                        n_accum = '0;
                        n_dc    = '0;
                    end
                    n_prev_colon = 1'b1;
                    n_at_start   = 1'b0;
                end else if (r_prev_colon) begin
                    if (r_gap) begin
                        fail = 1'b1;
                    end else begin
                        n_gap      = 1'b1;
                        n_at_start = 1'b0;
                    end
                end else if (r_at_start) begin
                    n_prev_colon = 1'b1;
                end else begin
                    fail = 1'b1;
                end
            end else begin
                fail = 1'b1;
            end
        end

        // end of string: flush the open group and check the group count
        if (i_last_char) begin
            ok    = !fail;
            fin_n = n_front + n_back;
            f2    = n_front;
            b2    = n_back;
            if (ok) begin
                if (n_dc != '0) begin
                    if (fin_n[GCNT_W-1]) begin
                        ok = 1'b0;
                    end else begin
                        entry.has_group = 1'b1;
                        entry.to_tail   = n_gap;
                        entry.idx       = fin_n[GIDX_W-1:0];
                        entry.group     = n_accum;
                        if (n_gap) begin
                            b2 = n_back + 1'b1;
                        end else begin
                            f2 = n_front + 1'b1;
                        end
                    end
                end else if (!(n_gap && n_prev_colon && n_back == '0)) begin
                    ok = 1'b0;
                end
            end
            if (ok) begin
                if (n_gap ? ((f2 + b2) > GCNT_W'(NUM_GROUPS - 1))
                          : ((f2 + b2) != GCNT_W'(NUM_GROUPS))) begin
                    ok = 1'b0;
                end
            end
            entry.finish = 1'b1;
            entry.ok     = ok;
            entry.nfront = f2;
            entry.nback  = b2;
        end
        n_failed = fail;
    end

    assign o_push  = i_accept && (colon_push || i_last_char);
    assign o_entry = entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accum      <= '0;
            r_dc         <= '0;
            r_front      <= '0;
            r_back       <= '0;
            r_gap        <= 1'b0;
            r_prev_colon <= 1'b0;
            r_at_start   <= 1'b1;
            r_cc         <= '0;
            r_failed     <= 1'b0;
        end else if (i_accept) begin
            if (i_last_char) begin
                r_accum      <= '0;
                r_dc         <= '0;
                r_front      <= '0;
                r_back       <= '0;
                r_gap        <= 1'b0;
                r_prev_colon <= 1'b0;
                r_at_start   <= 1'b1;
                r_cc         <= '0;
                r_failed     <= 1'b0;
            end else begin
                r_accum      <= n_accum;
                r_dc         <= n_dc;
                r_front      <= n_front;
                r_back       <= n_back;
                r_gap        <= n_gap;
                r_prev_colon <= n_prev_colon;
                r_at_start   <= n_at_start;
                r_cc         <= n_cc;
                r_failed     <= n_failed;
            end
        end
    end

endmodule

FILE: rtl/ipv6t_queue.sv
// Short FIFO of queue words between the parser front and back ends.
// Uses ipv6t_pkg for the word type and depth.
module ipv6t_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  ipv6t_pkg::t_qentry  i_data,
    input  logic                i_pop,
    output logic                o_full,
    output logic                o_nonempty,
    output ipv6t_pkg::t_qentry  o_head
);
    import ipv6t_pkg::*;

    t_qentry              r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [Q_PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [Q_CNT_W-1:0]   r_count, n_count;

    assign o_full     = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_nonempty = (r_count != '0);
    assign o_head     = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = i_pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

FILE: rtl/ipv6t_back.sv
// Back end of the IPv6 parser: group storage and address assembly.
// Front groups sit at their index, groups after the gap in a tail shift line. Uses ipv6t_pkg.
module ipv6t_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_q_nonempty,
    input  ipv6t_pkg::t_qentry             i_q_head,
    output logic                           o_q_pop,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [ipv6t_pkg::ADDR_W-1:0]   o_addr_high,
    output logic [ipv6t_pkg::ADDR_W-1:0]   o_addr_low,
    output logic                           o_valid_res
);
    import ipv6t_pkg::*;

    logic [GROUP_W-1:0] r_fstore [NUM_GROUPS];
    logic [GROUP_W-1:0] n_fstore [NUM_GROUPS];
    logic [GROUP_W-1:0] r_tail   [NUM_GROUPS];
    logic [GROUP_W-1:0] n_tail   [NUM_GROUPS];
    logic [GROUP_W-1:0] words    [NUM_GROUPS];

    logic               r_out_valid, n_out_valid;
    logic [ADDR_W-1:0]  r_hi, n_hi;
    logic [ADDR_W-1:0]  r_lo, n_lo;
    logic               r_ok, n_ok;
    logic               pop;

    assign pop     = i_q_nonempty && (!r_out_valid || !i_stall);
    assign o_q_pop = pop;

    always_comb begin
        for (int j = 0; j < NUM_GROUPS; j++) begin
            n_fstore[j] = r_fstore[j];
        end
        if (i_q_head.has_group && !i_q_head.to_tail) begin
            n_fstore[i_q_head.idx] = i_q_head.group;
        end
        for (int j = 0; j < NUM_GROUPS; j++) begin
            n_tail[j] = r_tail[j];
        end
        if (i_q_head.has_group && i_q_head.to_tail) begin
            for (int j = 0; j < NUM_GROUPS - 1; j++) begin
                n_tail[j] = r_tail[j + 1];
            end
            n_tail[NUM_GROUPS-1] = i_q_head.group;
        end

        for (int j = 0; j < NUM_GROUPS; j++) begin
            if (GCNT_W'(j) < i_q_head.nfront) begin
                words[j] = n_fstore[j];
            end else if ((GCNT_W+1)'(j) + {1'b0, i_q_head.nback}
                         >= (GCNT_W+1)'(NUM_GROUPS)) begin
                words[j] = n_tail[j];
            end else begin
                words[j] = '0;
            end
        end

        n_hi = '0;
        n_lo = '0;
        if (i_q_head.ok) begin
            for (int j = 0; j < NUM_GROUPS / 2; j++) begin
                n_hi[ADDR_W-1-GROUP_W*j -: GROUP_W] = words[j];
                n_lo[ADDR_W-1-GROUP_W*j -: GROUP_W] = words[j + NUM_GROUPS/2];
            end
        end
        n_ok = i_q_head.ok;

        n_out_valid = r_out_valid && i_stall;
        if (pop && i_q_head.finish) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            for (int j = 0; j < NUM_GROUPS; j++) begin
                r_fstore[j] <= n_fstore[j];
                r_tail[j]   <= n_tail[j];
            end
            if (i_q_head.finish) begin
                r_hi <= n_hi;
                r_lo <= n_lo;
                r_ok <= n_ok;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_addr_high = r_hi;
    assign o_addr_low  = r_lo;
    assign o_valid_res = r_ok;

endmodule

FILE: rtl/ipv6_text_to_binary_parser.sv
// IPv6 text-to-binary parser, top level. Takes one address character per word and returns
// the 128-bit address with a valid flag on the word marked last. Uses ipv6t_pkg and the
// ipv6t_front, ipv6t_queue and ipv6t_back modules.
//
// One character is taken every cycle unless o_stall is high. The result for a string passes
// through the queue and then the output register: the front end checks syntax and counts groups
// as the character is taken, a two-word queue hands group writes to the back end, and the
// back end expands the double colon and loads the output register. The input stalls only
// when that queue is full, which happens when the output side holds off a result.
module ipv6_text_to_binary_parser (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [ipv6t_pkg::CHAR_W-1:0]   i_text_char,
    input  logic                           i_last_char,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [ipv6t_pkg::ADDR_W-1:0]   o_addr_high,
    output logic [ipv6t_pkg::ADDR_W-1:0]   o_addr_low,
    output logic                           o_valid_res
);
    import ipv6t_pkg::*;

    logic    accept;
    logic    q_push;
    logic    q_pop;
    logic    q_full;
    logic    q_nonempty;
    t_qentry q_in;
    t_qentry q_head;

    assign o_stall = q_full;
    assign accept  = i_valid && !q_full;

    ipv6t_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_text_char (i_text_char),
        .i_last_char (i_last_char),
        .o_push      (q_push),
        .o_entry     (q_in)
    );

    ipv6t_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (q_push),
        .i_data     (q_in),
        .i_pop      (q_pop),
        .o_full     (q_full),
        .o_nonempty (q_nonempty),
        .o_head     (q_head)
    );

    ipv6t_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_nonempty (q_nonempty),
        .i_q_head     (q_head),
        .o_q_pop      (q_pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_addr_high  (o_addr_high),
        .o_addr_low   (o_addr_low),
        .o_valid_res  (o_valid_res)
    );

endmodule
